/* src/plfi_pkg.sv */
// ----------------------------------------------------------------------------
// plfi_pkg
// Shared types and constants of the particle force integrator.
// ----------------------------------------------------------------------------
package plfi_pkg;

    localparam int POS_W    = 24;
    localparam int REL_W    = 16;
    localparam int SUM_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SQ_W     = 51;
    localparam int SQ_STEPS = 25;
    localparam int DEN_W    = 32;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 66;
    localparam int ACC_W    = 48;
    localparam int REL_SHIFT = 14;
    localparam int CNT_W    = 5;

    typedef struct packed {
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic signed [POS_W-1:0] own_vx;
        logic signed [POS_W-1:0] own_vy;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic signed [REL_W-1:0] relation;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic signed [POS_W-1:0] new_vx;
        logic signed [POS_W-1:0] new_vy;
    } t_out_item;

    typedef struct packed {
        logic        [22:0]      interaction_radius;
        logic        [19:0]      repulsion_edge;
        logic        [22:0]      force_gain;
        logic        [22:0]      time_step;
        logic        [20:0]      velocity_retention;
        logic signed [POS_W-1:0] bound_low;
        logic signed [POS_W-1:0] bound_high;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_RADIUS     = 3'd0,
        REG_EDGE       = 3'd1,
        REG_GAIN       = 3'd2,
        REG_STEP       = 3'd3,
        REG_RETENTION  = 3'd4,
        REG_BOUND_LOW  = 3'd5,
        REG_BOUND_HIGH = 3'd6
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_RADIUS,
        OP_DIV_D,
        OP_DIV_STEP,
        OP_SET_D,
        OP_DIV_BETA,
        OP_SET_F_REP,
        OP_DIV_TENT,
        OP_MUL_TENT,
        OP_SET_F_TENT,
        OP_SET_F_ZERO,
        OP_MUL_F,
        OP_DIV_FORCE,
        OP_ACC,
        OP_MUL_K,
        OP_SET_K,
        OP_MUL_SK,
        OP_SET_FS,
        OP_MUL_VF,
        OP_SET_VF,
        OP_MUL_FSDT,
        OP_SET_NV,
        OP_MUL_NVDT,
        OP_SET_NP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic d_below_edge;
        logic d_in_tent;
        logic last;
    } t_status;

endpackage

/* src/plfi_regs.sv */
// ----------------------------------------------------------------------------
// plfi_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module plfi_regs
    import plfi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interaction_radius <= 23'd52429;
            r_cfg.repulsion_edge     <= 20'd314573;
            r_cfg.force_gain         <= 23'd5242880;
            r_cfg.time_step          <= 23'd31457;
            r_cfg.velocity_retention <= 21'd41943;
            r_cfg.bound_low          <= 24'sd0;
            r_cfg.bound_high         <= 24'sd1048576;
        end else if (wr) begin
            unique case (idx)
                REG_RADIUS:     r_cfg.interaction_radius <= pwdata[22:0];
                REG_EDGE:       r_cfg.repulsion_edge     <= pwdata[19:0];
                REG_GAIN:       r_cfg.force_gain         <= pwdata[22:0];
                REG_STEP:       r_cfg.time_step          <= pwdata[22:0];
                REG_RETENTION:  r_cfg.velocity_retention <= pwdata[20:0];
                REG_BOUND_LOW:  r_cfg.bound_low          <= $signed(pwdata[23:0]);
                REG_BOUND_HIGH: r_cfg.bound_high         <= $signed(pwdata[23:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RADIUS:     prdata = DATA_W'(r_cfg.interaction_radius);
            REG_EDGE:       prdata = DATA_W'(r_cfg.repulsion_edge);
            REG_GAIN:       prdata = DATA_W'(r_cfg.force_gain);
            REG_STEP:       prdata = DATA_W'(r_cfg.time_step);
            REG_RETENTION:  prdata = DATA_W'(r_cfg.velocity_retention);
            REG_BOUND_LOW:  prdata = DATA_W'(r_cfg.bound_low);
            REG_BOUND_HIGH: prdata = DATA_W'(r_cfg.bound_high);
            default:        prdata = '0;
        endcase
    end

endmodule

/* src/plfi_dp.sv */
// ----------------------------------------------------------------------------
// plfi_dp
// Datapath: shared multiplier, bit-serial square root and divider,
// force accumulators and the integration arithmetic.
// ----------------------------------------------------------------------------
module plfi_dp
    import plfi_pkg::*;
#(
    parameter int FRACTION_BITS = 20
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_data,
    input  t_cfg      i_cfg,
    output t_status   o_status,
    output t_out_item o_data
);

    localparam int F    = FRACTION_BITS;
    localparam int NDIV = F + 3;
    localparam int NUMW = F + 28;
    localparam int FW   = F + 3;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [PROD_W-1:0] MARGIN = PROD_W'((2**F + 500) / 1000);
    localparam logic signed [PROD_W-1:0] S32_HI = PROD_W'(2147483647);
    localparam logic signed [PROD_W-1:0] S32_LO = -S32_HI - 1;
    localparam logic signed [PROD_W-1:0] S24_HI = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] S24_LO = -S24_HI - 1;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = (x > S32_HI) ? S32_HI : ((x < S32_LO) ? S32_LO : x);
        return y[31:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = (x > S24_HI) ? S24_HI : ((x < S24_LO) ? S24_LO : x);
        return y[POS_W-1:0];
    endfunction

    logic signed [POS_W:0]    r_dx, r_dy;
    logic signed [POS_W-1:0]  r_ox, r_oy, r_vx, r_vy;
    logic signed [REL_W-1:0]  r_rel;
    logic                     r_last;
    logic signed [PROD_W-1:0] r_prod;
    logic        [49:0]       r_r2;
    logic        [SQ_W-1:0]   r_sq_v, r_sq_res, r_sq_bit;
    logic        [POS_W:0]    r_r;
    logic        [DEN_W-1:0]  r_dv_rem, r_dv_den;
    logic        [NDIV-1:0]   r_dv_low, r_dv_quo;
    logic        [F-1:0]      r_d;
    logic signed [FW-1:0]     r_f;
    logic                     r_fneg;
    logic signed [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic        [30:0]       r_k;
    logic signed [SUM_W-1:0]  r_fs;
    logic signed [ACC_W-1:0]  r_tmp;
    logic signed [POS_W-1:0]  r_nv;
    logic signed [POS_W-1:0]  r_new_x, r_new_y, r_new_vx, r_new_vy;
    t_out_item                r_out;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_full, prod_mag, prod_sh, acc_sum, np0, np1, np2;
    logic signed [PROD_W-1:0] lo_w, hi_w;
    logic        [PROD_W-1:0] k_full;
    logic        [F:0]        g;
    logic signed [31:0]       tdiff, tabs;
    logic        [NUMW-1:0]   dv_num;
    logic        [DEN_W-1:0]  dv_den;
    logic                     dv_start;
    logic        [DEN_W:0]    dv_sh, dv_diff;
    logic                     dv_ge;
    logic        [SQ_W-1:0]   sq_trial;
    logic                     sq_ge;
    logic signed [33:0]       acc_q;
    logic signed [SUM_W-1:0]  sum_sel;
    logic signed [POS_W-1:0]  v_sel, p_sel;

    assign sum_sel = i_cmd.axis ? r_sum_y : r_sum_x;
    assign v_sel   = i_cmd.axis ? r_vy : r_vx;
    assign p_sel   = i_cmd.axis ? r_oy : r_ox;
    assign g       = ONE - r_dv_quo[F:0];
    assign prod_sh = r_prod >>> F;
    assign prod_mag = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign k_full  = prod_sh;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQ_X: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(r_dx);
            end
            OP_SQ_Y: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            OP_MUL_TENT: begin
                mul_a = MUL_W'(r_rel);
                mul_b = $signed(MUL_W'(g));
            end
            OP_MUL_F: begin
                mul_a = i_cmd.axis ? MUL_W'(r_dy) : MUL_W'(r_dx);
                mul_b = MUL_W'(r_f);
            end
            OP_MUL_K: begin
                mul_a = $signed(MUL_W'(i_cfg.interaction_radius));
                mul_b = $signed(MUL_W'(i_cfg.force_gain));
            end
            OP_MUL_SK: begin
                mul_a = MUL_W'(sum_sel);
                mul_b = $signed(MUL_W'(r_k));
            end
            OP_MUL_VF: begin
                mul_a = MUL_W'(v_sel);
                mul_b = $signed(MUL_W'(i_cfg.velocity_retention));
            end
            OP_MUL_FSDT: begin
                mul_a = MUL_W'(r_fs);
                mul_b = $signed(MUL_W'(i_cfg.time_step));
            end
            OP_MUL_NVDT: begin
                mul_a = MUL_W'(r_nv);
                mul_b = $signed(MUL_W'(i_cfg.time_step));
            end
            default: ;
        endcase
    end

    assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign tdiff = $signed(32'({r_d, 1'b0})) - $signed(32'(ONE))
                 - $signed(32'(i_cfg.repulsion_edge));
    assign tabs  = (tdiff < 0) ? -tdiff : tdiff;

    always_comb begin
        dv_num   = '0;
        dv_den   = '0;
        dv_start = 1'b1;
        case (i_cmd.op)
            OP_DIV_D: begin
                dv_num = NUMW'({r_r, {F{1'b0}}});
                dv_den = DEN_W'(i_cfg.interaction_radius);
            end
            OP_DIV_BETA: begin
                dv_num = NUMW'({r_d, {F{1'b0}}});
                dv_den = DEN_W'(i_cfg.repulsion_edge);
            end
            OP_DIV_TENT: begin
                dv_num = NUMW'({tabs[F-1:0], {F{1'b0}}});
                dv_den = DEN_W'(ONE) - DEN_W'(i_cfg.repulsion_edge);
            end
            OP_DIV_FORCE: begin
                dv_num = prod_mag[NUMW-1:0];
                dv_den = DEN_W'(r_r);
            end
            default: dv_start = 1'b0;
        endcase
    end

    assign dv_sh   = {r_dv_rem, r_dv_low[NDIV-1]};
    assign dv_diff = dv_sh - {1'b0, r_dv_den};
    assign dv_ge   = dv_sh >= {1'b0, r_dv_den};

    assign sq_trial = r_sq_res + r_sq_bit;
    assign sq_ge    = r_sq_v >= sq_trial;

    assign acc_q   = r_fneg ? -$signed(34'(r_dv_quo)) : $signed(34'(r_dv_quo));
    assign acc_sum = PROD_W'(sum_sel) + PROD_W'(acc_q);

    assign lo_w = PROD_W'(i_cfg.bound_low);
    assign hi_w = PROD_W'(i_cfg.bound_high);
    assign np0  = PROD_W'(p_sel) + prod_sh;
    assign np1  = (np0 < lo_w) ? hi_w - MARGIN : np0;
    assign np2  = (np1 > hi_w) ? lo_w + MARGIN : np1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_cmd.op == OP_ACC) begin
            if (i_cmd.axis) begin
                r_sum_y <= sat32(acc_sum);
            end else begin
                r_sum_x <= sat32(acc_sum);
            end
        end else if (i_cmd.op == OP_EMIT) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            r_dv_rem <= DEN_W'(dv_num[NUMW-1:NDIV]);
            r_dv_low <= dv_num[NDIV-1:0];
            r_dv_quo <= '0;
            r_dv_den <= dv_den;
        end else if (i_cmd.op == OP_DIV_STEP) begin
            r_dv_rem <= dv_ge ? dv_diff[DEN_W-1:0] : dv_sh[DEN_W-1:0];
            r_dv_low <= r_dv_low << 1;
            r_dv_quo <= {r_dv_quo[NDIV-2:0], dv_ge};
        end
        if (i_cmd.op == OP_DIV_FORCE) begin
            r_fneg <= r_prod[PROD_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_dx   <= (POS_W+1)'(i_data.other_x) - (POS_W+1)'(i_data.own_x);
                r_dy   <= (POS_W+1)'(i_data.other_y) - (POS_W+1)'(i_data.own_y);
                r_ox   <= i_data.own_x;
                r_oy   <= i_data.own_y;
                r_vx   <= i_data.own_vx;
                r_vy   <= i_data.own_vy;
                r_rel  <= i_data.relation;
                r_last <= i_data.last;
            end
            OP_SQ_X, OP_MUL_TENT, OP_MUL_F, OP_MUL_K, OP_MUL_SK, OP_MUL_VF,
            OP_MUL_FSDT, OP_MUL_NVDT: begin
                r_prod <= prod_full;
            end
            OP_SQ_Y: begin
                r_r2   <= r_prod[49:0];
                r_prod <= prod_full;
            end
            OP_SQRT_INIT: begin
                r_sq_v   <= SQ_W'(r_r2) + SQ_W'(r_prod[49:0]);
                r_sq_res <= '0;
                r_sq_bit <= SQ_W'(1) << 48;
            end
            OP_SQRT_STEP: begin
                if (sq_ge) begin
                    r_sq_v   <= r_sq_v - sq_trial;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            OP_RADIUS:     r_r <= r_sq_res[POS_W:0];
            OP_SET_D:      r_d <= r_dv_quo[F-1:0];
            OP_SET_F_REP:  r_f <= $signed(FW'(r_dv_quo[F-1:0])) - $signed(FW'(ONE));
            OP_SET_F_TENT: r_f <= FW'(r_prod >>> REL_SHIFT);
            OP_SET_F_ZERO: r_f <= '0;
            OP_SET_K:      r_k <= (k_full > PROD_W'(31'h7fffffff)) ? '1 : k_full[30:0];
            OP_SET_FS:     r_fs <= sat32(prod_sh);
            OP_SET_VF:     r_tmp <= ACC_W'(prod_sh);
            OP_SET_NV:     r_nv <= sat24(PROD_W'(r_tmp) + prod_sh);
            OP_SET_NP: begin
                if (i_cmd.axis) begin
                    r_new_y  <= sat24(np2);
                    r_new_vy <= r_nv;
                end else begin
                    r_new_x  <= sat24(np2);
                    r_new_vx <= r_nv;
                end
            end
            OP_EMIT: begin
                r_out.new_x  <= r_new_x;
                r_out.new_y  <= r_new_y;
                r_out.new_vx <= r_new_vx;
                r_out.new_vy <= r_new_vy;
            end
            default: ;
        endcase
    end

    assign o_status.skip = (r_r == '0) || (r_r >= (POS_W+1)'(i_cfg.interaction_radius));
    assign o_status.d_below_edge = DEN_W'(r_d) < DEN_W'(i_cfg.repulsion_edge);
    assign o_status.d_in_tent    = DEN_W'(r_d) > DEN_W'(i_cfg.repulsion_edge);
    assign o_status.last         = r_last;
    assign o_data                = r_out;

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_STEP) |-> (r_dv_rem < r_dv_den))
        else $error("divider remainder not below divisor");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SQRT_STEP) |-> $onehot(r_sq_bit))
        else $error("square root bit lost");

    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ACC) |-> (r_dv_quo <= NDIV'(2**(F+1))))
        else $error("force term out of range");

endmodule

/* src/plfi_ctrl.sv */
// ----------------------------------------------------------------------------
// plfi_ctrl
// Sequencer: steps the datapath through one neighbour and the final update.
// ----------------------------------------------------------------------------
module plfi_ctrl
    import plfi_pkg::*;
#(
    parameter int FRACTION_BITS = 20
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int NDIV = FRACTION_BITS + 3;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_X, S_SQ_Y, S_SQRT_INIT, S_SQRT, S_RADIUS, S_CHECK,
        S_DIV_RUN, S_SET_D, S_BRANCH, S_SET_REP, S_MUL_TENT, S_SET_TENT,
        S_MUL_F, S_FDIV, S_ACC, S_LASTCHK, S_MUL_K, S_SET_K, S_I_MUL_SK,
        S_I_SET_FS, S_I_MUL_VF, S_I_SET_VF, S_I_MUL_FSDT, S_I_SET_NV,
        S_I_MUL_NVDT, S_I_SET_NP, S_EMIT
    } t_state;

    t_state           r_state, r_ret;
    logic [CNT_W-1:0] r_cnt;
    logic             r_axis;
    logic             r_out_valid;
    logic             out_free;

    assign out_free = !(r_out_valid && i_stall);
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        o_cmd.axis = r_axis;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE:       o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            S_SQ_X:       o_cmd.op = OP_SQ_X;
            S_SQ_Y:       o_cmd.op = OP_SQ_Y;
            S_SQRT_INIT:  o_cmd.op = OP_SQRT_INIT;
            S_SQRT:       o_cmd.op = OP_SQRT_STEP;
            S_RADIUS:     o_cmd.op = OP_RADIUS;
            S_CHECK:      o_cmd.op = i_status.skip ? OP_NONE : OP_DIV_D;
            S_DIV_RUN:    o_cmd.op = OP_DIV_STEP;
            S_SET_D:      o_cmd.op = OP_SET_D;
            S_BRANCH: begin
                if (i_status.d_below_edge) begin
                    o_cmd.op = OP_DIV_BETA;
                end else if (i_status.d_in_tent) begin
                    o_cmd.op = OP_DIV_TENT;
                end else begin
                    o_cmd.op = OP_SET_F_ZERO;
                end
            end
            S_SET_REP:    o_cmd.op = OP_SET_F_REP;
            S_MUL_TENT:   o_cmd.op = OP_MUL_TENT;
            S_SET_TENT:   o_cmd.op = OP_SET_F_TENT;
            S_MUL_F:      o_cmd.op = OP_MUL_F;
            S_FDIV:       o_cmd.op = OP_DIV_FORCE;
            S_ACC:        o_cmd.op = OP_ACC;
            S_LASTCHK:    o_cmd.op = OP_NONE;
            S_MUL_K:      o_cmd.op = OP_MUL_K;
            S_SET_K:      o_cmd.op = OP_SET_K;
            S_I_MUL_SK:   o_cmd.op = OP_MUL_SK;
            S_I_SET_FS:   o_cmd.op = OP_SET_FS;
            S_I_MUL_VF:   o_cmd.op = OP_MUL_VF;
            S_I_SET_VF:   o_cmd.op = OP_SET_VF;
            S_I_MUL_FSDT: o_cmd.op = OP_MUL_FSDT;
            S_I_SET_NV:   o_cmd.op = OP_SET_NV;
            S_I_MUL_NVDT: o_cmd.op = OP_MUL_NVDT;
            S_I_SET_NP:   o_cmd.op = OP_SET_NP;
            S_EMIT:       o_cmd.op = out_free ? OP_EMIT : OP_NONE;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_axis <= 1'b0;
                    if (i_valid) begin
                        r_state <= S_SQ_X;
                    end
                end
                S_SQ_X:      r_state <= S_SQ_Y;
                S_SQ_Y:      r_state <= S_SQRT_INIT;
                S_SQRT_INIT: r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_RADIUS;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RADIUS: r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_status.skip) begin
                        r_state <= S_LASTCHK;
                    end else begin
                        r_ret   <= S_SET_D;
                        r_state <= S_DIV_RUN;
                    end
                end
                S_DIV_RUN: begin
                    if (r_cnt == CNT_W'(NDIV - 1)) begin
                        r_cnt   <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SET_D: r_state <= S_BRANCH;
                S_BRANCH: begin
                    if (i_status.d_below_edge) begin
                        r_ret   <= S_SET_REP;
                        r_state <= S_DIV_RUN;
                    end else if (i_status.d_in_tent) begin
                        r_ret   <= S_MUL_TENT;
                        r_state <= S_DIV_RUN;
                    end else begin
                        r_state <= S_MUL_F;
                    end
                end
                S_SET_REP:  r_state <= S_MUL_F;
                S_MUL_TENT: r_state <= S_SET_TENT;
                S_SET_TENT: r_state <= S_MUL_F;
                S_MUL_F:    r_state <= S_FDIV;
                S_FDIV: begin
                    r_ret   <= S_ACC;
                    r_state <= S_DIV_RUN;
                end
                S_ACC: begin
                    r_axis  <= !r_axis;
                    r_state <= r_axis ? S_LASTCHK : S_MUL_F;
                end
                S_LASTCHK: r_state <= i_status.last ? S_MUL_K : S_IDLE;
                S_MUL_K:      r_state <= S_SET_K;
                S_SET_K:      r_state <= S_I_MUL_SK;
                S_I_MUL_SK:   r_state <= S_I_SET_FS;
                S_I_SET_FS:   r_state <= S_I_MUL_VF;
                S_I_MUL_VF:   r_state <= S_I_SET_VF;
                S_I_SET_VF:   r_state <= S_I_MUL_FSDT;
                S_I_MUL_FSDT: r_state <= S_I_SET_NV;
                S_I_SET_NV:   r_state <= S_I_MUL_NVDT;
                S_I_MUL_NVDT: r_state <= S_I_SET_NP;
                S_I_SET_NP: begin
                    r_axis  <= !r_axis;
                    r_state <= r_axis ? S_EMIT : S_I_MUL_SK;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    a_div_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RUN) |-> (r_ret == S_SET_D || r_ret == S_SET_REP
                                    || r_ret == S_MUL_TENT || r_ret == S_ACC))
        else $error("bad divider return state");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("step counter not cleared");

endmodule

/* src/particle_life_force_integrator_unit.sv */
// ----------------------------------------------------------------------------
// particle_life_force_integrator_unit
// Accumulates neighbour forces on one particle and integrates its state.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_data): one neighbour per transfer, with
// the particle's own position and velocity repeated on every transfer of a run.
// The transfer flagged last closes the run and produces one result on the
// output channel (o_valid / i_stall / o_data); other transfers produce none.
// One neighbour at a time is processed. Each one runs the bit-serial square
// root (25 steps); an in-range one also takes up to four passes of the shared
// one-bit-per-cycle divider (F+3 steps each). The last transfer adds the
// integration on the shared multiplier.
// The result sits in an output register, so the next run can start while it
// waits; a second result waits in the emit step until the first is taken.
// Reset clears the force sums, empties the output register and loads the
// configuration defaults. Configuration must be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module particle_life_force_integrator_unit
    import plfi_pkg::*;
#(
    parameter int FRACTION_BITS = 20
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    plfi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    plfi_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    plfi_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_data   (i_data),
        .i_cfg    (cfg),
        .o_status (status),
        .o_data   (o_data)
    );

endmodule
